// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/rxpc_pkg.sv =====
`timescale 1ns / 1ps

package rxpc_pkg;

   // Request kinds carried on tuser
   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_PAYLOAD = 1'b1;

   // Mask applied to the key seeding shift amounts
   localparam logic [1:0] SHIFT_MASK = 2'h3;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      MODE_PLAIN     = 2'd0,
      MODE_XOR_SEQ   = 2'd1,
      MODE_ROLLING   = 2'd2,
      MODE_PLAIN_ALT = 2'd3
   } mode_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] frame_seq;
      logic [7:0]  header_crc;
      logic [15:0] payload_len;
      logic [1:0]  mode;
      logic        decrypt;
      logic [7:0]  in_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } result_type;

endpackage

// ===== design/rxpc_in_reg.sv =====
`timescale 1ns / 1ps

module rxpc_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rxpc_pkg::item_type in_item,
   input  logic               advance,
   output logic               held_valid,
   output rxpc_pkg::item_type held_item
);

   logic               valid_ff;
   logic               valid_in;
   rxpc_pkg::item_type item_ff;

   // Take a new request whenever the held one leaves or none is held
   assign in_ready = !reset && (!valid_ff || advance);

   always_comb begin
      valid_in = valid_ff;
      if (in_ready && in_valid) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on acceptance
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

// ===== design/rxpc_core.sv =====
`timescale 1ns / 1ps

module rxpc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 held_valid,
   input  rxpc_pkg::item_type   held_item,
   input  logic                 out_free,
   output logic                 advance,
   output logic                 res_valid,
   output rxpc_pkg::result_type result
);

   logic [7:0]         key_bytes_ff [3];
   logic [7:0]         key_bytes_in [3];
   logic [1:0]         key_phase_ff;
   logic [1:0]         key_phase_in;
   logic [15:0]        bytes_left_ff;
   logic [15:0]        bytes_left_in;
   rxpc_pkg::mode_type active_mode_ff;
   rxpc_pkg::mode_type active_mode_in;
   logic               active_direction_ff;
   logic               active_direction_in;
   logic [7:0]         seq_low_byte_ff;
   logic [7:0]         seq_low_byte_in;

   logic               is_start;
   logic               produce;
   logic [1:0]         phase;
   logic [7:0]         key;
   logic [7:0]         out_byte;
   logic [7:0]         cipher;
   logic [15:0]        bytes_left_dec;
   logic [31:0]        crc_wide;
   logic [31:0]        seed0;
   logic [31:0]        seed1;
   logic [31:0]        seed2;

   // Decide whether the held request yields a byte and can move on
   assign is_start       = (held_item.kind == rxpc_pkg::KIND_START);
   assign produce        = held_valid && !is_start && (bytes_left_ff != 16'd0);
   assign advance        = held_valid && (!produce || out_free);
   assign res_valid      = produce && out_free;
   assign bytes_left_dec = bytes_left_ff - 16'd1;

   // Pick the key byte; phase three falls back to phase zero
   assign phase = (key_phase_ff == 2'd3) ? 2'd0 : key_phase_ff;
   assign key   = key_bytes_ff[phase];

   // Transform the payload byte
   always_comb begin
      case (active_mode_ff)
         rxpc_pkg::MODE_XOR_SEQ: out_byte = held_item.in_byte ^ seq_low_byte_ff;
         rxpc_pkg::MODE_ROLLING: out_byte = held_item.in_byte ^ key;
         default:                out_byte = held_item.in_byte;
      endcase
   end

   assign cipher = active_direction_ff ? held_item.in_byte : out_byte;

   assign result.out_byte  = out_byte;
   assign result.last_byte = (bytes_left_dec == 16'd0);

   // Seed the three key bytes from sequence number, header CRC and payload length
   assign crc_wide = {24'd0, held_item.header_crc};
   assign seed0 = (held_item.frame_seq ^ ~crc_wide)
                  >> (held_item.frame_seq[1:0] & rxpc_pkg::SHIFT_MASK);
   assign seed1 = (~held_item.frame_seq ^ ~crc_wide)
                  >> (held_item.payload_len[1:0] & rxpc_pkg::SHIFT_MASK);
   assign seed2 = (~held_item.frame_seq ^ crc_wide)
                  >> ((held_item.payload_len[1:0] ^ held_item.frame_seq[1:0])
                      & rxpc_pkg::SHIFT_MASK);

   // Next frame state
   always_comb begin
      key_bytes_in        = key_bytes_ff;
      key_phase_in        = key_phase_ff;
      bytes_left_in       = bytes_left_ff;
      active_mode_in      = active_mode_ff;
      active_direction_in = active_direction_ff;
      seq_low_byte_in     = seq_low_byte_ff;
      if (held_valid && is_start) begin
         active_mode_in      = rxpc_pkg::mode_type'(held_item.mode);
         active_direction_in = held_item.decrypt;
         seq_low_byte_in     = held_item.frame_seq[7:0];
         bytes_left_in       = held_item.payload_len;
         key_phase_in        = 2'd0;
         if (held_item.mode == rxpc_pkg::MODE_ROLLING) begin
            key_bytes_in[0] = seed0[7:0];
            key_bytes_in[1] = seed1[7:0];
            key_bytes_in[2] = seed2[7:0];
         end
      end else if (res_valid) begin
         bytes_left_in = bytes_left_dec;
         if (active_mode_ff == rxpc_pkg::MODE_ROLLING) begin
            key_bytes_in[phase] = key ^ cipher;
            key_phase_in        = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_bytes_ff[0]     <= 8'd0;
         key_bytes_ff[1]     <= 8'd0;
         key_bytes_ff[2]     <= 8'd0;
         key_phase_ff        <= 2'd0;
         bytes_left_ff       <= 16'd0;
         active_mode_ff      <= rxpc_pkg::MODE_PLAIN;
         active_direction_ff <= 1'b0;
         seq_low_byte_ff     <= 8'd0;
      end else begin
         key_bytes_ff        <= key_bytes_in;
         key_phase_ff        <= key_phase_in;
         bytes_left_ff       <= bytes_left_in;
         active_mode_ff      <= active_mode_in;
         active_direction_ff <= active_direction_in;
         seq_low_byte_ff     <= seq_low_byte_in;
      end
   end

endmodule

// ===== design/rxpc_out_reg.sv =====
`timescale 1ns / 1ps

module rxpc_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 res_valid,
   input  rxpc_pkg::result_type result,
   output logic                 out_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rxpc_pkg::result_type rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   rxpc_pkg::result_type result_ff;

   // Free when empty or drained this cycle
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new result; hold it while the receiver stalls
   always_ff @(posedge clock) begin
      if (res_valid) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== design/rolling_xor_payload_cipher.sv =====
`timescale 1ns / 1ps

// Payload scrambler for a framed link.
// Request channel (req_*): tuser = 0 is a frame start carrying sequence number,
// header CRC byte, payload length, mode and direction; tuser = 1 is one payload
// byte. Response channel (rsp_*): one transformed byte per payload byte within
// the frame length, tlast set on the final byte. Frame starts and bytes past
// the length give no response.
// A payload request is captured in the input register, passes through the
// core into the result register once that register is free, and is offered
// on the response side from there. Throughput: one request per cycle while
// the response side keeps up; the key update for a byte is combinational
// between the two registers, so bytes may arrive back to back.
// Reset (synchronous, active high) empties both registers, zeroes the key
// bytes, phase and remaining length, and selects the plain mode; req_tready is
// low while reset is asserted.
// When the receiver holds rsp_tready low, the result register keeps its byte,
// the input register still takes one more request, and req_tready then drops
// until the response is taken. Frame starts and dropped bytes keep flowing
// through while a response waits.

module rolling_xor_payload_cipher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [31:0] frame_seq, [39:32] header_crc, [55:40] payload_len, [57:56] mode,
   // [58] decrypt, [66:59] in_byte, [71:67] zero
   input  logic [rxpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] kind
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] out_byte
   output logic [rxpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   rxpc_pkg::item_type   req_item;
   rxpc_pkg::item_type   held_item;
   rxpc_pkg::result_type result;
   rxpc_pkg::result_type rsp_result;
   logic                 held_valid;
   logic                 advance;
   logic                 res_valid;
   logic                 out_free;

   // Unpack the request
   assign req_item.kind        = req_tuser;
   assign req_item.frame_seq   = req_tdata[31:0];
   assign req_item.header_crc  = req_tdata[39:32];
   assign req_item.payload_len = req_tdata[55:40];
   assign req_item.mode        = req_tdata[57:56];
   assign req_item.decrypt     = req_tdata[58];
   assign req_item.in_byte     = req_tdata[66:59];

   rxpc_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   rxpc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .held_valid (held_valid),
      .held_item  (held_item),
      .out_free   (out_free),
      .advance    (advance),
      .res_valid  (res_valid),
      .result     (result)
   );

   rxpc_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_result (rsp_result)
   );

   // Pack the response
   assign rsp_tdata = rsp_result.out_byte;
   assign rsp_tlast = rsp_result.last_byte;

endmodule

// ===== design/rxpc_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rxpc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [rxpc_pkg::REQ_DATA_W-1:0]   req_tdata,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [rxpc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);

   logic req_fire;
   logic start_fire;

   assign req_fire   = req_tvalid && req_tready;
   assign start_fire = req_fire && (req_tuser == rxpc_pkg::KIND_START) && (req_tdata != '1);

   // Stalled response holds its byte and flag
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))

   // Response register is empty right after reset
   `ASSERT_NEXT(a_rsp_reset, clock, 1'b0, reset, !rsp_tvalid)

   // A fresh response comes from a request accepted just before it passed through both registers
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_tvalid), $past(req_fire, 2))

   // A frame start with data not all ones never yields the fresh response a payload byte in its place would
   `ASSERT_IMPLIES(a_start_silent, clock, reset, $past(start_fire, 2), !$rose(rsp_tvalid))

endmodule

bind rolling_xor_payload_cipher rxpc_checker u_rxpc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import rxpc_pkg::*;

   // Expected bytes of the scrambler, predicted from each accepted request
   class cipher_scoreboard;
      logic [7:0]  key_bytes [3];
      logic [1:0]  key_phase;
      logic [15:0] bytes_left;
      mode_type    active_mode;
      logic        decrypt_dir;
      logic [7:0]  seq_byte;
      result_type  pending_bytes [$];
      int          failures;

      function new();
         key_bytes[0] = 8'h00;
         key_bytes[1] = 8'h00;
         key_bytes[2] = 8'h00;
         key_phase    = 2'd0;
         bytes_left   = 16'd0;
         active_mode  = MODE_PLAIN;
         decrypt_dir  = 1'b0;
         seq_byte     = 8'h00;
         failures     = 0;
      endfunction

      // Update frame state and queue the byte this request produces, if any
      function void note_request(item_type it);
         logic [31:0] crc_ext;
         logic [31:0] seed;
         logic [1:0]  ph;
         logic [7:0]  k;
         logic [7:0]  r;
         result_type  expected;
         if (it.kind == KIND_START) begin
            active_mode = mode_type'(it.mode);
            decrypt_dir = it.decrypt;
            seq_byte    = it.frame_seq[7:0];
            bytes_left  = it.payload_len;
            key_phase   = 2'd0;
            if (active_mode == MODE_ROLLING) begin
               crc_ext = {24'h0, it.header_crc};
               seed = (it.frame_seq ^ ~crc_ext) >> (it.frame_seq[1:0] & SHIFT_MASK);
               key_bytes[0] = seed[7:0];
               seed = (~it.frame_seq ^ ~crc_ext) >> (it.payload_len[1:0] & SHIFT_MASK);
               key_bytes[1] = seed[7:0];
               seed = (~it.frame_seq ^ crc_ext)
                      >> ((it.payload_len[1:0] ^ it.frame_seq[1:0]) & SHIFT_MASK);
               key_bytes[2] = seed[7:0];
            end
         end else if (bytes_left != 16'd0) begin
            case (active_mode)
               MODE_XOR_SEQ: begin
                  r = it.in_byte ^ seq_byte;
               end
               MODE_ROLLING: begin
                  ph = (key_phase == 2'd3) ? 2'd0 : key_phase;
                  k  = key_bytes[ph];
                  r  = it.in_byte ^ k;
                  // fold the ciphertext into the key byte just used
                  key_bytes[ph] = k ^ (decrypt_dir ? it.in_byte : r);
                  key_phase = (ph == 2'd2) ? 2'd0 : ph + 2'd1;
               end
               default: begin
                  r = it.in_byte;
               end
            endcase
            bytes_left = bytes_left - 16'd1;
            expected.out_byte  = r;
            expected.last_byte = (bytes_left == 16'd0);
            pending_bytes.push_back(expected);
         end
      endfunction

      // Compare one accepted response with the oldest expected byte
      function void check_result(logic [7:0] out_byte, logic last_byte);
         result_type expected;
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected response byte %h last %b", $time, out_byte, last_byte);
            failures++;
         end else begin
            expected = pending_bytes.pop_front();
            if (out_byte !== expected.out_byte) begin
               $display("%0t: out_byte expected %h actual %h", $time,
                        expected.out_byte, out_byte);
               failures++;
            end
            if (last_byte !== expected.last_byte) begin
               $display("%0t: last_byte expected %b actual %b", $time,
                        expected.last_byte, last_byte);
               failures++;
            end
         end
      endfunction

      function int outstanding();
         return pending_bytes.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   cipher_scoreboard sb;
   bit steady_flow      = 1'b0;
   bit hold_off_pending = 1'b0;
   int items_sent       = 0;

   rolling_xor_payload_cipher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // Watch both handshakes: predict on each request, check each response
   always @(posedge clock) begin
      item_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            seen.kind        = req_tuser;
            seen.frame_seq   = req_tdata[31:0];
            seen.header_crc  = req_tdata[39:32];
            seen.payload_len = req_tdata[55:40];
            seen.mode        = req_tdata[57:56];
            seen.decrypt     = req_tdata[58];
            seen.in_byte     = req_tdata[66:59];
            sb.note_request(seen);
         end
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tlast);
      end
   end

   // Drive the receiver: random stalls, a steady stretch and one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (steady_flow) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 18);
         end
      end
   end

   // Offer one request and hold it until accepted; then maybe idle a little
   task automatic send_request(input item_type it);
      req_tdata  <= {5'b0, it.in_byte, it.decrypt, it.mode, it.payload_len,
                     it.header_crc, it.frame_seq};
      req_tuser  <= it.kind;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (!steady_flow && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_start(input logic [31:0] seq, input logic [7:0] crc,
                             input logic [15:0] len, input mode_type mode,
                             input logic dec);
      item_type it;
      it.kind        = KIND_START;
      it.frame_seq   = seq;
      it.header_crc  = crc;
      it.payload_len = len;
      it.mode        = mode;
      it.decrypt     = dec;
      it.in_byte     = 8'($urandom);
      send_request(it);
   endtask

   // Payload request; the frame fields carry random junk the block must ignore
   task automatic send_payload(input logic [7:0] data);
      item_type it;
      it.kind        = KIND_PAYLOAD;
      it.frame_seq   = $urandom;
      it.header_crc  = 8'($urandom);
      it.payload_len = 16'($urandom);
      it.mode        = 2'($urandom);
      it.decrypt     = 1'($urandom);
      it.in_byte     = data;
      send_request(it);
   endtask

   task automatic send_frame(input mode_type mode, input logic [15:0] len, input int nbytes);
      send_start($urandom, 8'($urandom), len, mode, 1'($urandom));
      for (int i = 0; i < nbytes; i++)
         send_payload(8'($urandom));
      items_sent += 1 + ((nbytes < int'(len)) ? nbytes : int'(len));
   endtask

   initial begin
      int          pick;
      int          nbytes;
      int          waited;
      logic [15:0] len;
      mode_type    mode;
      bit          held_off = 1'b0;
      bit          drained  = 1'b0;

      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: stray byte after reset, plain modes, seq XOR, key wrap,
      // decrypt with extreme seeds, abandoned frame, zero length, past length
      send_payload(8'h5A);
      send_start(32'h0000_0000, 8'h00, 16'd2, MODE_PLAIN, 1'b0);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_start(32'h1234_5678, 8'hAB, 16'd1, MODE_PLAIN_ALT, 1'b1);
      send_payload(8'hA5);
      send_start(32'hFFFF_FFFF, 8'hFF, 16'd2, MODE_XOR_SEQ, 1'b0);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_start(32'h0000_0000, 8'h00, 16'd4, MODE_ROLLING, 1'b0);
      send_payload(8'h00);
      send_payload(8'hFF);
      send_payload(8'h3C);
      send_payload(8'hC3);
      send_start(32'hFFFF_FFFF, 8'hFF, 16'hFFFF, MODE_ROLLING, 1'b1);
      send_payload(8'hFF);
      send_payload(8'h00);
      send_payload(8'h81);
      send_start(32'hDEAD_BEEF, 8'h7E, 16'd0, MODE_XOR_SEQ, 1'b0);
      send_payload(8'h42);
      send_start(32'h8000_0003, 8'h80, 16'd1, MODE_ROLLING, 1'b0);
      send_payload(8'h11);
      send_payload(8'h22);

      // Random: mostly well-formed frames, some stray bytes and cut-short frames
      while (items_sent < 1800) begin
         steady_flow = (items_sent >= 300 && items_sent < 550);
         if (!held_off && items_sent >= 900) begin
            // Stall the response side while requests keep coming
            held_off = 1'b1;
            hold_off_pending = 1'b1;
            steady_flow = 1'b1;
            send_frame(MODE_ROLLING, 16'd40, 40);
            steady_flow = 1'b0;
         end
         if (!drained && items_sent >= 1300) begin
            // Hold the request side until every expected byte is back
            drained = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (sb.outstanding() != 0);
            repeat (4) @(posedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 6) begin
            send_payload(8'($urandom));
         end else begin
            mode = mode_type'($urandom_range(3));
            pick = $urandom_range(99);
            if (pick < 8)
               len = 16'd0;
            else if (pick < 16)
               len = 16'($urandom);
            else
               len = 16'($urandom_range(1, 12));
            if (len > 16'd12) begin
               nbytes = $urandom_range(1, 16);
            end else begin
               pick = $urandom_range(99);
               if (pick < 70)
                  nbytes = int'(len);
               else if (pick < 85)
                  nbytes = int'(len) + $urandom_range(1, 2);
               else
                  nbytes = $urandom_range(0, int'(len));
            end
            send_frame(mode, len, nbytes);
         end
      end
      req_tvalid <= 1'b0;

      // Drain: wait for the last expected bytes, then let the clock run on before the final check
      waited = 0;
      while (sb.outstanding() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (sb.outstanding() != 0) begin
         $display("%0t: %0d expected bytes never arrived", $time, sb.outstanding());
         sb.failures++;
      end
      if (sb.failures == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
